// File: hw/rtl/cda_pkg.sv
// Package for the Gregorian date unit: widths, request and state codes,
// controller/datapath command and status structs, calendar functions.
// No dependencies; every other file of the block imports it.
package cda_pkg;

  // Width of a day number counted from 1900-01-01.
  localparam int unsigned DAY_NUMBER_BITS = 17;

  // Validation window and calendar constants.
  localparam logic [11:0] BASE_YEAR = 12'd1900;
  localparam logic [11:0] LAST_YEAR = 12'd2030;
  localparam logic [3:0]  LAST_MONTH = 4'd12;

  // Field widths.
  localparam int unsigned YEAR_W  = 12;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned OFF_W   = 18;
  localparam int unsigned DIFF_W  = 17;
  // Year counter of the walk; wide enough for the largest day number.
  localparam int unsigned WALK_YEAR_W = 13;
  // Signed width that holds day number plus offset and the clamp limit.
  localparam int unsigned SUM_W = (DAY_NUMBER_BITS > 18) ? DAY_NUMBER_BITS + 2 : 20;
  // Stream widths.
  localparam int unsigned IN_TDATA_W  = 64;
  localparam int unsigned OUT_TDATA_W = 40;
  localparam int unsigned TUSER_W     = 2;

  // Request kinds.
  typedef enum logic [1:0] {
    REQ_ADD  = 2'd0,
    REQ_DIFF = 2'd1,
    REQ_LESS = 2'd2
  } req_e;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_A_YEAR,
    ST_A_MONTH,
    ST_B_YEAR,
    ST_B_MONTH,
    ST_SUM,
    ST_D_YEAR,
    ST_D_MONTH,
    ST_RESULT
  } state_e;

  // Datapath operations.
  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_YSTEP,
    OP_MSTEP,
    OP_SAVE_A,
    OP_SAVE_B,
    OP_SUM,
    OP_EMIT
  } op_e;

  // Command from controller to datapath.
  typedef struct packed {
    op_e  op;
    logic sel_b;    // walk targets date B instead of date A
    logic to_date;  // walk turns a day number into a date
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic [1:0] req;       // captured request kind
    logic       yr_more;   // another year step is due
    logic       mo_more;   // another month step is due
    logic       out_free;  // output register can take a result
  } sts_t;

  // Result item, first field in the highest bits.
  typedef struct packed {
    logic               out_of_range;
    logic               is_less;
    logic [DIFF_W-1:0]  diff_days;
    logic [DAY_W-1:0]   res_day;
    logic [MONTH_W-1:0] res_month;
    logic [YEAR_W-1:0]  res_year;
  } out_item_t;

  // Length of a month; zero for a month number that does not exist.
  function automatic logic [4:0] month_len(input logic leap, input logic [3:0] m);
    logic [4:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // Leap rule inside the validation window, where 1900 is the only
  // century year that is not a leap year.
  function automatic logic leap_window(input logic [11:0] y);
    return (y[1:0] == 2'b00) && (y != BASE_YEAR);
  endfunction

  // True when the date lies in the window and names a real day.
  function automatic logic date_ok(input logic [11:0] y, input logic [3:0] m,
                                   input logic [4:0] d);
    return (y >= BASE_YEAR) && (y <= LAST_YEAR) && (d != 5'd0) &&
           (d <= month_len(leap_window(y), m));
  endfunction

endpackage

// File: hw/rtl/calendar_date_arithmetic.sv
// Top level of the Gregorian date unit: controller plus datapath.
// Depends on cda_pkg, cda_ctrl and cda_datapath.
//
// Usage: a request enters on the slave stream; tuser carries the request
// kind (0 add offset to A, 1 absolute day difference, 2 A before B).
// Dates outside 1900-01-01..2030-12-31 or impossible dates count as
// 1900-01-01. Each request yields exactly one result on the master stream.
// One request is worked on at a time; tready is high only while idle.
// A less-than request goes from the idle state straight to the result state.
// Add and difference walk year by year and month by month through one
// shared adder for each date conversion, after the step that takes the
// request and before the step that loads the result; the back conversion
// of an add can cover up to 359 years.
// A finished result waits in the output register; a new request is taken
// while it waits, and the next result holds until the receiver takes it.
// Reset clears the controller and the output valid flag; no clearing pass.
module calendar_date_arithmetic (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // tdata: year_a[11:0], month_a[15:12], day_a[20:16], year_b[32:21],
  //        month_b[36:33], day_b[41:37], offset_days[59:42], zero[63:60]
  input  logic [63:0] s_axis_tdata_i,
  // tuser: req_type[1:0]
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // tdata: res_year[11:0], res_month[15:12], res_day[20:16],
  //        diff_days[37:21], is_less[38], out_of_range[39]
  output logic [39:0] m_axis_tdata_o
);
  import cda_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Request sequencing.
  cda_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .sts_i           (sts),
    .cmd_o           (cmd)
  );

  // Calendar arithmetic and output register.
  cda_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cmd_i           (cmd),
    .sts_o           (sts)
  );

endmodule

// File: hw/rtl/cda_ctrl.sv
// Controller state machine of the Gregorian date unit.
// Sequences the datapath walks through commands; depends on cda_pkg.
module cda_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  input  cda_pkg::sts_t sts_i,
  output cda_pkg::cmd_t cmd_o
);
  import cda_pkg::*;

  state_e state_q, state_d;
  logic   accept;

  assign accept = s_axis_tvalid_i && (state_q == ST_IDLE);

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          // Less and unknown requests need no conversion.
          if (sts_i.req == REQ_ADD || sts_i.req == REQ_DIFF) begin
            state_d = ST_A_YEAR;
          end else begin
            state_d = ST_RESULT;
          end
        end
      end
      ST_A_YEAR:  if (!sts_i.yr_more) state_d = ST_A_MONTH;
      ST_A_MONTH: begin
        if (!sts_i.mo_more) begin
          state_d = (sts_i.req == REQ_ADD) ? ST_SUM : ST_B_YEAR;
        end
      end
      ST_B_YEAR:  if (!sts_i.yr_more) state_d = ST_B_MONTH;
      ST_B_MONTH: if (!sts_i.mo_more) state_d = ST_RESULT;
      ST_SUM:     state_d = ST_D_YEAR;
      ST_D_YEAR:  if (!sts_i.yr_more) state_d = ST_D_MONTH;
      ST_D_MONTH: if (!sts_i.mo_more) state_d = ST_RESULT;
      ST_RESULT:  if (sts_i.out_free) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // Outputs: handshake and datapath command.
  always_comb begin
    s_axis_tready_o = 1'b0;
    cmd_o.op        = OP_NOP;
    cmd_o.sel_b     = 1'b0;
    cmd_o.to_date   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (accept) cmd_o.op = OP_LOAD;
      end
      ST_A_YEAR: begin
        if (sts_i.yr_more) cmd_o.op = OP_YSTEP;
      end
      ST_A_MONTH: begin
        cmd_o.op = sts_i.mo_more ? OP_MSTEP : OP_SAVE_A;
      end
      ST_B_YEAR: begin
        cmd_o.sel_b = 1'b1;
        if (sts_i.yr_more) cmd_o.op = OP_YSTEP;
      end
      ST_B_MONTH: begin
        cmd_o.sel_b = 1'b1;
        cmd_o.op    = sts_i.mo_more ? OP_MSTEP : OP_SAVE_B;
      end
      ST_SUM: begin
        cmd_o.op = OP_SUM;
      end
      ST_D_YEAR: begin
        cmd_o.to_date = 1'b1;
        if (sts_i.yr_more) cmd_o.op = OP_YSTEP;
      end
      ST_D_MONTH: begin
        cmd_o.to_date = 1'b1;
        if (sts_i.mo_more) cmd_o.op = OP_MSTEP;
      end
      ST_RESULT: begin
        if (sts_i.out_free) cmd_o.op = OP_EMIT;
      end
      default: begin
        cmd_o.op = OP_NOP;
      end
    endcase
  end

endmodule

// File: hw/rtl/cda_datapath.sv
// Datapath of the Gregorian date unit: validated operands, the year and
// month walk with its accumulator, the clamp and the output register.
// Depends on cda_pkg; driven by cda_ctrl.
module cda_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [cda_pkg::IN_TDATA_W-1:0]   s_axis_tdata_i,
  input  logic [cda_pkg::TUSER_W-1:0]      s_axis_tuser_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  output logic [cda_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o,
  input  cda_pkg::cmd_t                    cmd_i,
  output cda_pkg::sts_t                    sts_o
);
  import cda_pkg::*;

  localparam int unsigned ACC_W = DAY_NUMBER_BITS;
  localparam logic [SUM_W-2:0] MAX_NUM = (SUM_W-1)'((64'd1 << DAY_NUMBER_BITS) - 64'd1);

  // Raw request fields.
  logic [YEAR_W-1:0]  in_ya, in_yb;
  logic [MONTH_W-1:0] in_ma, in_mb;
  logic [DAY_W-1:0]   in_da, in_db;
  logic               ok_a, ok_b;

  // Operand and result registers.
  logic [1:0]              req_q;
  logic [YEAR_W-1:0]       ya_q, yb_q;
  logic [MONTH_W-1:0]      ma_q, mb_q;
  logic [DAY_W-1:0]        da_q, db_q;
  logic signed [OFF_W-1:0] off_q;
  logic [ACC_W-1:0]        na_q;
  logic [DIFF_W-1:0]       diff_q;
  logic                    oor_q;

  // Walk registers.
  logic [WALK_YEAR_W-1:0] cy_q;
  logic [1:0]             c4_q;
  logic [6:0]             c100_q;
  logic [8:0]             c400_q;
  logic [MONTH_W-1:0]     cm_q;
  logic [ACC_W-1:0]       acc_q;

  // Output register.
  logic      out_valid_q;
  out_item_t out_q, out_d;

  // Walk helpers.
  logic                   leap;
  logic [8:0]             ylen;
  logic [4:0]             mlen;
  logic [WALK_YEAR_W-1:0] ty;
  logic [MONTH_W-1:0]     tm;
  logic [ACC_W-1:0]       nb;
  logic signed [SUM_W-1:0] na_ext, off_ext, sum;
  logic                   sum_neg, sum_over;

  assign in_ya = s_axis_tdata_i[11:0];
  assign in_ma = s_axis_tdata_i[15:12];
  assign in_da = s_axis_tdata_i[20:16];
  assign in_yb = s_axis_tdata_i[32:21];
  assign in_mb = s_axis_tdata_i[36:33];
  assign in_db = s_axis_tdata_i[41:37];
  assign ok_a  = date_ok(in_ya, in_ma, in_da);
  assign ok_b  = date_ok(in_yb, in_mb, in_db);

  // Leap year from the walk's residue counters, then year and month lengths.
  assign leap = (c4_q == 2'd0) && ((c100_q != 7'd0) || (c400_q == 9'd0));
  assign ylen = leap ? 9'd366 : 9'd365;
  assign mlen = month_len(leap, cm_q);
  assign ty   = WALK_YEAR_W'(cmd_i.sel_b ? yb_q : ya_q);
  assign tm   = cmd_i.sel_b ? mb_q : ma_q;
  assign nb   = acc_q + ACC_W'(db_q) - ACC_W'(1);

  // Signed sum of day number and offset with range checks.
  assign na_ext   = SUM_W'(na_q);
  assign off_ext  = SUM_W'(off_q);
  assign sum      = na_ext + off_ext;
  assign sum_neg  = sum[SUM_W-1];
  assign sum_over = !sum_neg && (sum[SUM_W-2:0] > MAX_NUM);

  // Status towards the controller.
  assign sts_o.req      = cmd_i.op == OP_LOAD ? s_axis_tuser_i : req_q;
  assign sts_o.yr_more  = cmd_i.to_date ? (acc_q >= ACC_W'(ylen)) : (cy_q != ty);
  assign sts_o.mo_more  = cmd_i.to_date ? ((cm_q != LAST_MONTH) && (acc_q >= ACC_W'(mlen)))
                                        : (cm_q != tm);
  assign sts_o.out_free = !out_valid_q || m_axis_tready_i;

  // Result item for the captured request kind.
  always_comb begin
    out_d = '0;
    unique case (req_q)
      REQ_ADD: begin
        out_d.res_year     = cy_q[YEAR_W-1:0];
        out_d.res_month    = cm_q;
        out_d.res_day      = DAY_W'(acc_q) + DAY_W'(1);
        out_d.out_of_range = oor_q;
      end
      REQ_DIFF: out_d.diff_days = diff_q;
      REQ_LESS: out_d.is_less = {ya_q, ma_q, da_q} < {yb_q, mb_q, db_q};
      default:  out_d = '0;
    endcase
  end

  // Operands, walk and result registers.
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LOAD: begin
        req_q <= s_axis_tuser_i;
        ya_q  <= ok_a ? in_ya : BASE_YEAR;
        ma_q  <= ok_a ? in_ma : MONTH_W'(1);
        da_q  <= ok_a ? in_da : DAY_W'(1);
        yb_q  <= ok_b ? in_yb : BASE_YEAR;
        mb_q  <= ok_b ? in_mb : MONTH_W'(1);
        db_q  <= ok_b ? in_db : DAY_W'(1);
        off_q <= s_axis_tdata_i[59:42];
      end
      default: ;
    endcase
    // The walk restarts at 1900-01 after a load, a saved conversion or the sum.
    unique case (cmd_i.op)
      OP_LOAD, OP_SAVE_A, OP_SAVE_B, OP_SUM: begin
        cy_q   <= WALK_YEAR_W'(BASE_YEAR);
        c4_q   <= 2'd0;
        c100_q <= 7'd0;
        c400_q <= 9'd300;
        cm_q   <= MONTH_W'(1);
        if (cmd_i.op == OP_SAVE_A) na_q <= acc_q + ACC_W'(da_q) - ACC_W'(1);
        if (cmd_i.op == OP_SAVE_B) begin
          diff_q <= DIFF_W'((na_q >= nb) ? (na_q - nb) : (nb - na_q));
        end
        // The sum seeds the back conversion, clamped to the day-number range.
        if (cmd_i.op == OP_SUM) begin
          oor_q <= sum_neg || sum_over;
          if (sum_neg) begin
            acc_q <= '0;
          end else if (sum_over) begin
            acc_q <= ACC_W'(MAX_NUM);
          end else begin
            acc_q <= ACC_W'(sum);
          end
        end else begin
          acc_q <= '0;
        end
      end
      OP_YSTEP: begin
        cy_q   <= cy_q + WALK_YEAR_W'(1);
        c4_q   <= c4_q + 2'd1;
        c100_q <= (c100_q == 7'd99) ? 7'd0 : c100_q + 7'd1;
        c400_q <= (c400_q == 9'd399) ? 9'd0 : c400_q + 9'd1;
        acc_q  <= cmd_i.to_date ? acc_q - ACC_W'(ylen) : acc_q + ACC_W'(ylen);
      end
      OP_MSTEP: begin
        cm_q  <= cm_q + MONTH_W'(1);
        acc_q <= cmd_i.to_date ? acc_q - ACC_W'(mlen) : acc_q + ACC_W'(mlen);
      end
      default: ;
    endcase
    if (cmd_i.op == OP_EMIT) out_q <= out_d;
  end

  // Output valid: set on a new result, cleared when the result is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == OP_EMIT) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q;

endmodule

// File: tb/calendar_date_arithmetic_tb.sv
// Self-checking testbench for the Gregorian date unit: directed and random
// add, difference, less-than and unknown-kind requests, checked against a built-in predictor.
// Depends on cda_pkg and calendar_date_arithmetic.
module calendar_date_arithmetic_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cda_pkg::*;

  // Request kind that the block does not know; it must answer with zeros.
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;

  localparam int unsigned RANDOM_ITEMS   = 2000;
  localparam int unsigned DRAIN_EVERY    = 500;
  localparam int unsigned TAIL_CYCLES    = 600;
  localparam int unsigned WATCHDOG_LIMIT = 5000;

  // One date request as the sender sees it.
  typedef struct packed {
    logic [1:0]  kind;
    logic [11:0] year_a;
    logic [3:0]  month_a;
    logic [4:0]  day_a;
    logic [11:0] year_b;
    logic [3:0]  month_b;
    logic [4:0]  day_b;
    logic [17:0] offset;
  } date_req_t;

  // Calendar predictor and the queue of results still owed by the block.
  class date_result_board;
    out_item_t   expected_results[$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned clamped;
    int unsigned per_kind[4];

    static function bit leap_year(int y);
      return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
    endfunction

    static function int days_in_month(int y, int m);
      case (m)
        1, 3, 5, 7, 8, 10, 12: return 31;
        4, 6, 9, 11:           return 30;
        2:                     return leap_year(y) ? 29 : 28;
        default:               return 0;
      endcase
    endfunction

    // Dates outside the window or naming no real day fall back to 1900-01-01.
    static function void sanitise(inout int y, inout int m, inout int d);
      if (y < int'(BASE_YEAR) || y > int'(LAST_YEAR) || m < 1 || m > 12 ||
          d < 1 || d > days_in_month(y, m)) begin
        y = int'(BASE_YEAR);
        m = 1;
        d = 1;
      end
    endfunction

    static function int day_number(int y, int m, int d);
      int n;
      n = 0;
      for (int k = int'(BASE_YEAR); k < y; k++) n += leap_year(k) ? 366 : 365;
      for (int k = 1; k < m; k++) n += days_in_month(y, k);
      return n + d - 1;
    endfunction

    static function void day_to_date(int n, output int y, output int m, output int d);
      y = int'(BASE_YEAR);
      m = 1;
      while (n >= (leap_year(y) ? 366 : 365)) begin
        n -= leap_year(y) ? 366 : 365;
        y++;
      end
      while (m < 12 && n >= days_in_month(y, m)) begin
        n -= days_in_month(y, m);
        m++;
      end
      d = n + 1;
    endfunction

    function out_item_t predict_result(date_req_t rq);
      out_item_t r;
      int ya, ma, da, yb, mb, db;
      int off, sum, last_day, gap;
      int ry, rm, rd;
      r  = '0;
      ya = rq.year_a;
      ma = rq.month_a;
      da = rq.day_a;
      yb = rq.year_b;
      mb = rq.month_b;
      db = rq.day_b;
      sanitise(ya, ma, da);
      sanitise(yb, mb, db);
      off      = $signed(rq.offset);
      last_day = (1 << DAY_NUMBER_BITS) - 1;
      case (rq.kind)
        REQ_ADD: begin
          sum = day_number(ya, ma, da) + off;
          // Sums past either end of the day-number range are clamped.
          if (sum < 0) begin
            sum = 0;
            r.out_of_range = 1'b1;
          end else if (sum > last_day) begin
            sum = last_day;
            r.out_of_range = 1'b1;
          end
          day_to_date(sum, ry, rm, rd);
          r.res_year  = ry[11:0];
          r.res_month = rm[3:0];
          r.res_day   = rd[4:0];
        end
        REQ_DIFF: begin
          gap = day_number(ya, ma, da) - day_number(yb, mb, db);
          if (gap < 0) gap = -gap;
          r.diff_days = gap[DIFF_W-1:0];
        end
        REQ_LESS: begin
          if (ya != yb)      r.is_less = ya < yb;
          else if (ma != mb) r.is_less = ma < mb;
          else               r.is_less = da < db;
        end
        default: ;
      endcase
      return r;
    endfunction

    function void note_request(date_req_t rq);
      out_item_t r;
      r = predict_result(rq);
      per_kind[rq.kind]++;
      if (r.out_of_range) clamped++;
      expected_results.push_back(r);
    endfunction

    function void check_result(logic [39:0] word);
      out_item_t got, want;
      got = word;
      if (expected_results.size() == 0) begin
        mismatches++;
        $display("[%0t] result %h arrived with no request outstanding", $time, word);
        return;
      end
      want = expected_results.pop_front();
      checked++;
      if (got !== want) begin
        mismatches++;
        $display("[%0t] mismatch: expected %0d-%0d-%0d diff %0d less %0b clamp %0b,",
                 $time, want.res_year, want.res_month, want.res_day, want.diff_days,
                 want.is_less, want.out_of_range);
        $display("          got %0d-%0d-%0d diff %0d less %0b clamp %0b",
                 got.res_year, got.res_month, got.res_day, got.diff_days,
                 got.is_less, got.out_of_range);
      end
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction
  endclass

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [63:0] s_axis_tdata_i  = '0;
  logic [1:0]  s_axis_tuser_i  = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [39:0] m_axis_tdata_o;

  int unsigned src_idle_pct = 31;
  int unsigned snk_idle_pct = 65;

  date_result_board board = new();

  calendar_date_arithmetic i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  // Clock with a 2 ns period.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Receiver stalls at random with the current idle share.
  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= snk_idle_pct);
  end

  // Every result taken by the receiver is checked against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) board.check_result(m_axis_tdata_o);
  end

  // Watchdog: ends the run if no request moves on either side for too long.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
        quiet = 0;
      else
        quiet++;
    end
    $display("[%0t] no request moved for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  function automatic date_req_t make_req(logic [1:0] kind, int ya, int ma, int da,
                                         int yb, int mb, int db, int off);
    date_req_t rq;
    rq.kind    = kind;
    rq.year_a  = ya[11:0];
    rq.month_a = ma[3:0];
    rq.day_a   = da[4:0];
    rq.year_b  = yb[11:0];
    rq.month_b = mb[3:0];
    rq.day_b   = db[4:0];
    rq.offset  = off[17:0];
    return rq;
  endfunction

  // Mostly real dates, biased to early years to keep conversions short,
  // with some dates just outside the window or the month and some noise.
  function automatic void pick_date(output logic [11:0] y, output logic [3:0] m,
                                    output logic [4:0] d);
    int unsigned r;
    int yy, mm, len;
    r = $urandom_range(99);
    if (r < 10) begin
      y = 12'($urandom_range(4095));
      m = 4'($urandom_range(15));
      d = 5'($urandom_range(31));
    end else begin
      yy  = ($urandom_range(99) < 60) ? int'($urandom_range(1950, 1900))
                                      : int'($urandom_range(2030, 1900));
      mm  = int'($urandom_range(12, 1));
      len = date_result_board::days_in_month(yy, mm);
      if (r < 14) yy = ($urandom_range(1) != 0) ? 1899 : 2031;
      y = yy[11:0];
      m = mm[3:0];
      d = (r >= 14 && r < 18) ? 5'(len + 1) : 5'($urandom_range(len, 1));
    end
  endfunction

  function automatic logic [17:0] pick_offset();
    int unsigned r;
    int o;
    r = $urandom_range(99);
    if (r < 30)      o = int'($urandom_range(80)) - 40;
    else if (r < 60) o = int'($urandom_range(800)) - 400;
    else if (r < 80) o = int'($urandom_range(120000)) - 60000;
    else             o = int'($urandom_range(262143));
    return o[17:0];
  endfunction

  function automatic date_req_t random_request();
    date_req_t rq;
    int unsigned r;
    r = $urandom_range(99);
    if (r < 40)      rq.kind = REQ_ADD;
    else if (r < 68) rq.kind = REQ_DIFF;
    else if (r < 93) rq.kind = REQ_LESS;
    else             rq.kind = REQ_UNKNOWN;
    pick_date(rq.year_a, rq.month_a, rq.day_a);
    pick_date(rq.year_b, rq.month_b, rq.day_b);
    // Comparisons often need B close to A to reach the month and day tests.
    if (rq.kind == REQ_LESS && $urandom_range(99) < 40) begin
      rq.year_b  = rq.year_a;
      rq.month_b = rq.month_a;
      rq.day_b   = rq.day_a;
      case ($urandom_range(2))
        0:       ;
        1:       rq.day_b = 5'($urandom_range(28, 1));
        default: rq.month_b = 4'($urandom_range(12, 1));
      endcase
    end
    rq.offset = (rq.kind == REQ_ADD) ? pick_offset() : 18'($urandom_range(262143));
    return rq;
  endfunction

  // Offers one request after a random idle gap and waits until it is taken.
  task automatic send_request(input date_req_t rq);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= rq.kind;
    s_axis_tdata_i  <= {4'b0000, rq.offset, rq.day_b, rq.month_b, rq.year_b,
                        rq.day_a, rq.month_a, rq.year_a};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    board.note_request(rq);
  endtask

  // Holds the sender off until every outstanding result has been taken.
  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  // Stimulus: reset, directed corner cases, then three phases of random requests.
  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Additions around both ends of the range, leap days and fallback dates.
    send_request(make_req(REQ_ADD, 1900, 1, 1, 0, 0, 0, 0));
    send_request(make_req(REQ_ADD, 1900, 1, 1, 0, 0, 0, -1));
    send_request(make_req(REQ_ADD, 1900, 1, 1, 0, 0, 0, -131072));
    send_request(make_req(REQ_ADD, 1900, 1, 1, 0, 0, 0, 131071));
    send_request(make_req(REQ_ADD, 2030, 12, 31, 0, 0, 0, 131071));
    send_request(make_req(REQ_ADD, 2030, 12, 31, 0, 0, 0, 1));
    send_request(make_req(REQ_ADD, 2000, 2, 28, 0, 0, 0, 1));
    send_request(make_req(REQ_ADD, 1900, 2, 28, 0, 0, 0, 1));
    send_request(make_req(REQ_ADD, 2000, 3, 1, 0, 0, 0, -1));
    send_request(make_req(REQ_ADD, 2031, 1, 1, 0, 0, 0, 10));
    send_request(make_req(REQ_ADD, 1899, 12, 31, 0, 0, 0, 5));
    send_request(make_req(REQ_ADD, 2020, 4, 31, 0, 0, 0, 0));
    send_request(make_req(REQ_ADD, 2001, 2, 29, 0, 0, 0, 0));
    send_request(make_req(REQ_ADD, 1950, 0, 0, 0, 0, 0, 3));
    send_request(make_req(REQ_ADD, 4095, 15, 31, 0, 0, 0, 131071));
    // Differences at full span, both orders, zero and a fallback date.
    send_request(make_req(REQ_DIFF, 1900, 1, 1, 2030, 12, 31, 0));
    send_request(make_req(REQ_DIFF, 2030, 12, 31, 1900, 1, 1, 0));
    send_request(make_req(REQ_DIFF, 1984, 7, 15, 1984, 7, 15, 0));
    send_request(make_req(REQ_DIFF, 1999, 13, 1, 2000, 1, 1, 0));
    // Comparisons decided by year, by month, by day, and equal dates.
    send_request(make_req(REQ_LESS, 1999, 12, 31, 2000, 1, 1, 0));
    send_request(make_req(REQ_LESS, 2000, 1, 1, 1999, 12, 31, 0));
    send_request(make_req(REQ_LESS, 2010, 5, 20, 2010, 5, 20, 0));
    send_request(make_req(REQ_LESS, 2010, 5, 19, 2010, 6, 1, 0));
    send_request(make_req(REQ_LESS, 2010, 5, 21, 2010, 5, 20, 0));
    // Unknown kind with every data bit set.
    send_request(make_req(REQ_UNKNOWN, 4095, 15, 31, 4095, 15, 31, -1));
    drain_results();

    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 3) begin
        src_idle_pct = 65;
        snk_idle_pct <= 31;
      end
      if (i == 2 * RANDOM_ITEMS / 3) begin
        src_idle_pct = 0;
        snk_idle_pct <= 0;
      end
      if (i % DRAIN_EVERY == DRAIN_EVERY - 1) drain_results();
      send_request(random_request());
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Covered %0d add (%0d clamped), %0d difference, %0d less-than, %0d unknown requests.",
             board.per_kind[REQ_ADD], board.clamped, board.per_kind[REQ_DIFF],
             board.per_kind[REQ_LESS], board.per_kind[REQ_UNKNOWN]);
    $display("%0d results checked, %0d mismatches, %0d still outstanding.",
             board.checked, board.mismatches, board.pending());
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
